@@ sv/pps_pkg.sv @@
// Package for the priority process scheduler: command and status codes,
// slot placement codes, transaction payload structs and scheduler states.
// No dependencies.
package pps_pkg;

    typedef enum logic [2:0] {
        OP_CREATE = 3'd0,
        OP_BLOCK  = 3'd1,
        OP_WAKE   = 3'd2,
        OP_KILL   = 3'd3,
        OP_TICK   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_IDLE      = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        WHERE_READY   = 2'd0,
        WHERE_RUNNING = 2'd1,
        WHERE_BLOCKED = 2'd2
    } where_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] proc_id;
        logic [7:0]  priority_req;
        logic [15:0] need_time;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        run_valid;
        logic [15:0] run_id;
        logic [15:0] run_left;
        logic [15:0] run_used;
        logic        finished;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_EXEC,
        S_DONE
    } state_t;

endpackage

@@ sv/priority_process_scheduler.sv @@
// Priority process scheduler: one command transaction in, one result out.
// A command passes through an accept state, a sweep in which a single read
// port visits every slot once (one slot per cycle, its data registered before
// the comparison), an execute state and a result state during which the
// write-back lands. A stalled result holds the scheduler in the result state.
// Slot valid bits sit in flip-flops and clear at reset; the table memory holds
// id, priority, time counters, set and ready stamp. The result sits in an
// output register, and the next command is taken once that result has been
// accepted. Depends on pps_pkg.
module priority_process_scheduler #(
    parameter int MAX_PROCS = 16,
    parameter int PRIO_BITS = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  pps_pkg::cmd_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output pps_pkg::rsp_t  m_data
);

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = IW + 1;

    typedef struct packed {
        logic [15:0]          ident;
        logic [PRIO_BITS-1:0] prio;
        logic [15:0]          left;
        logic [15:0]          used;
        logic [1:0]           where;
        logic [31:0]          stamp;
    } slot_t;

    // Process table memory
    slot_t mem [MAX_PROCS];
    slot_t rd_data_reg;

    pps_pkg::state_t state_reg, state_next;
    logic [MAX_PROCS-1:0] valid_reg;
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [31:0] entry_counter_reg;
    pps_pkg::cmd_t cmd_reg;
    pps_pkg::rsp_t rsp_reg;

    // Scan findings
    logic          id_hit_reg, run_hit_reg, best_hit_reg, free_hit_reg;
    logic [IW-1:0] id_idx_reg, run_idx_reg, best_idx_reg, free_idx_reg;
    slot_t         id_slot_reg, run_slot_reg, best_slot_reg;

    // Write-back
    logic    wr_en_reg;
    logic [IW-1:0] wr_idx_reg;
    slot_t   wr_data_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pps_pkg::S_IDLE: if (s_valid) state_next = pps_pkg::S_SCAN;
            pps_pkg::S_SCAN: if (cnt_reg == CW'(MAX_PROCS)) state_next = pps_pkg::S_LAST;
            pps_pkg::S_LAST: state_next = pps_pkg::S_EXEC;
            pps_pkg::S_EXEC: state_next = pps_pkg::S_DONE;
            pps_pkg::S_DONE: if (m_ready) state_next = pps_pkg::S_IDLE;
            default: state_next = pps_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready = aresetn && (state_reg == pps_pkg::S_IDLE);
        m_valid = (state_reg == pps_pkg::S_DONE);
        m_data  = rsp_reg;
    end

    // Memory port: one read per cycle, one write from the execute registers
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_idx_reg];
        if (wr_en_reg) begin
            mem[wr_idx_reg] <= wr_data_reg;
        end
    end

    // Scan comparisons against the slot read last cycle
    logic [IW-1:0] cur_idx;
    logic          cur_ok;
    logic          better;
    always_comb begin
        cur_idx = IW'(cnt_reg - CW'(2));
        cur_ok  = valid_reg[cur_idx];
        better  = !best_hit_reg
            || (rd_data_reg.prio > best_slot_reg.prio)
            || ((rd_data_reg.prio == best_slot_reg.prio)
                && ((entry_counter_reg - rd_data_reg.stamp)
                    > (entry_counter_reg - best_slot_reg.stamp)));
    end

    // Execute: read-modify-write of the chosen slot and result build
    slot_t         ex_slot;
    logic [IW-1:0] ex_idx;
    logic          ex_wr;
    logic          ex_free;
    logic          ex_fin;
    logic [2:0]    ex_status;
    logic          ex_cnt_inc;
    logic          run_after;
    slot_t         run_view;
    always_comb begin
        ex_slot    = id_slot_reg;
        ex_idx     = id_idx_reg;
        ex_wr      = 1'b0;
        ex_free    = 1'b0;
        ex_fin     = 1'b0;
        ex_status  = pps_pkg::ST_OK;
        ex_cnt_inc = 1'b0;
        run_after  = run_hit_reg;
        run_view   = run_slot_reg;
        priority case (cmd_reg.operation)
            pps_pkg::OP_CREATE: begin
                if (id_hit_reg) begin
                    ex_status = pps_pkg::ST_DUPLICATE;
                end else if (!free_hit_reg) begin
                    ex_status = pps_pkg::ST_FULL;
                end else begin
                    ex_idx      = free_idx_reg;
                    ex_slot.ident = cmd_reg.proc_id;
                    ex_slot.prio  = PRIO_BITS'(cmd_reg.priority_req);
                    ex_slot.left  = cmd_reg.need_time;
                    ex_slot.used  = '0;
                    ex_slot.where = pps_pkg::WHERE_READY;
                    ex_slot.stamp = entry_counter_reg;
                    ex_wr       = 1'b1;
                    ex_cnt_inc  = 1'b1;
                end
            end
            pps_pkg::OP_BLOCK: begin
                if (run_hit_reg && run_slot_reg.ident == cmd_reg.proc_id) begin
                    ex_idx        = run_idx_reg;
                    ex_slot       = run_slot_reg;
                    ex_slot.where = pps_pkg::WHERE_BLOCKED;
                    ex_wr         = 1'b1;
                    run_after     = 1'b0;
                end else begin
                    ex_status = pps_pkg::ST_NOT_FOUND;
                end
            end
            pps_pkg::OP_WAKE: begin
                if (id_hit_reg && id_slot_reg.where == pps_pkg::WHERE_BLOCKED) begin
                    ex_slot.where = pps_pkg::WHERE_READY;
                    ex_slot.stamp = entry_counter_reg;
                    ex_wr         = 1'b1;
                    ex_cnt_inc    = 1'b1;
                end else begin
                    ex_status = pps_pkg::ST_NOT_FOUND;
                end
            end
            pps_pkg::OP_KILL: begin
                if (id_hit_reg) begin
                    ex_free = 1'b1;
                    if (id_idx_reg == run_idx_reg) run_after = 1'b0;
                end else begin
                    ex_status = pps_pkg::ST_NOT_FOUND;
                end
            end
            pps_pkg::OP_TICK: begin
                if (run_hit_reg || best_hit_reg) begin
                    ex_idx  = run_hit_reg ? run_idx_reg : best_idx_reg;
                    ex_slot = run_hit_reg ? run_slot_reg : best_slot_reg;
                    ex_slot.where = pps_pkg::WHERE_RUNNING;
                    if (ex_slot.used != 16'hFFFF) ex_slot.used = ex_slot.used + 16'd1;
                    if (ex_slot.left != 16'd0) ex_slot.left = ex_slot.left - 16'd1;
                    ex_wr = 1'b1;
                    if (ex_slot.left == 16'd0) begin
                        ex_fin  = 1'b1;
                        ex_free = 1'b1;
                    end
                    run_after = 1'b1;
                    run_view  = ex_slot;
                end else begin
                    ex_status = pps_pkg::ST_IDLE;
                end
            end
            default: ex_status = pps_pkg::ST_OK;
        endcase
    end

    // Control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= pps_pkg::S_IDLE;
            valid_reg         <= '0;
            entry_counter_reg <= '0;
            wr_en_reg         <= 1'b0;
            cnt_reg           <= '0;
            rd_idx_reg        <= '0;
        end else begin
            state_reg <= state_next;
            wr_en_reg <= 1'b0;
            priority case (state_reg)
                pps_pkg::S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg      <= s_data;
                        cnt_reg      <= CW'(1);
                        rd_idx_reg   <= '0;
                        id_hit_reg   <= 1'b0;
                        run_hit_reg  <= 1'b0;
                        best_hit_reg <= 1'b0;
                        free_hit_reg <= 1'b0;
                        id_idx_reg   <= '0;
                        run_idx_reg  <= '0;
                        best_idx_reg <= '0;
                        free_idx_reg <= '0;
                    end
                end
                pps_pkg::S_SCAN, pps_pkg::S_LAST: begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg < CW'(MAX_PROCS)) begin
                        rd_idx_reg <= IW'(cnt_reg);
                    end
                    // cnt_reg >= 2 means rd_data_reg holds slot cnt_reg-2
                    if (cnt_reg >= CW'(2)) begin
                        if (!cur_ok && !free_hit_reg) begin
                            free_hit_reg <= 1'b1;
                            free_idx_reg <= cur_idx;
                        end
                        if (cur_ok && !id_hit_reg && rd_data_reg.ident == cmd_reg.proc_id) begin
                            id_hit_reg  <= 1'b1;
                            id_idx_reg  <= cur_idx;
                            id_slot_reg <= rd_data_reg;
                        end
                        if (cur_ok && !run_hit_reg
                                && rd_data_reg.where == pps_pkg::WHERE_RUNNING) begin
                            run_hit_reg  <= 1'b1;
                            run_idx_reg  <= cur_idx;
                            run_slot_reg <= rd_data_reg;
                        end
                        if (cur_ok && rd_data_reg.where == pps_pkg::WHERE_READY && better) begin
                            best_hit_reg  <= 1'b1;
                            best_idx_reg  <= cur_idx;
                            best_slot_reg <= rd_data_reg;
                        end
                    end
                end
                pps_pkg::S_EXEC: begin
                    wr_en_reg   <= ex_wr;
                    wr_idx_reg  <= ex_idx;
                    wr_data_reg <= ex_slot;
                    if (ex_cnt_inc) entry_counter_reg <= entry_counter_reg + 32'd1;
                    if (cmd_reg.operation == pps_pkg::OP_CREATE && ex_wr) begin
                        valid_reg[ex_idx] <= 1'b1;
                    end
                    if (ex_free) valid_reg[ex_idx] <= 1'b0;
                    rsp_reg.status    <= ex_status;
                    rsp_reg.finished  <= ex_fin;
                    rsp_reg.run_valid <= run_after;
                    rsp_reg.run_id    <= run_after ? run_view.ident : 16'd0;
                    rsp_reg.run_left  <= run_after ? run_view.left : 16'd0;
                    rsp_reg.run_used  <= run_after ? run_view.used : 16'd0;
                end
                default: begin
                end
            endcase
        end
    end

    // Assertions
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("command accepted while busy");
    a_fin_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.finished) |-> (m_data.run_valid && m_data.run_left == 16'd0))
        else $error("finished result without run fields");
    a_idle_norun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == pps_pkg::ST_IDLE) |-> !m_data.run_valid)
        else $error("idle tick reports a running process");
    a_wr_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en_reg |-> $past(state_reg == pps_pkg::S_EXEC))
        else $error("table write outside execute");

endmodule

@@ test/tb_top.sv @@
// Testbench for the priority process scheduler: drives command transactions,
// predicts each result with a scoreboard class and checks every field.
// Depends on pps_pkg and priority_process_scheduler.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROC = 16;
    localparam int CYCLE_LIMIT = 400000;

    // Scoreboard: table model plus queue of expected results
    class sched_scoreboard;
        bit              valid_q [NPROC];
        logic [15:0]     ident_q [NPROC];
        logic [7:0]      prio_q  [NPROC];
        logic [15:0]     left_q  [NPROC];
        logic [15:0]     used_q  [NPROC];
        pps_pkg::where_t where_q [NPROC];
        logic [31:0]     stamp_q [NPROC];
        logic [31:0]     entries;
        pps_pkg::rsp_t   pending[$];
        int              errors;

        function int find_id(logic [15:0] id);
            for (int i = 0; i < NPROC; i++)
                if (valid_q[i] && ident_q[i] == id) return i;
            return -1;
        endfunction

        function int find_running();
            for (int i = 0; i < NPROC; i++)
                if (valid_q[i] && where_q[i] == pps_pkg::WHERE_RUNNING) return i;
            return -1;
        endfunction

        function int pick_ready();
            int b;
            b = -1;
            for (int i = 0; i < NPROC; i++) begin
                if (!valid_q[i] || where_q[i] != pps_pkg::WHERE_READY) continue;
                if (b < 0 || prio_q[i] > prio_q[b] ||
                    (prio_q[i] == prio_q[b] &&
                     (entries - stamp_q[i]) > (entries - stamp_q[b])))
                    b = i;
            end
            return b;
        endfunction

        function void enqueue_ready(int s);
            where_q[s] = pps_pkg::WHERE_READY;
            stamp_q[s] = entries;
            entries++;
        endfunction

        function int live_count();
            int n;
            n = 0;
            foreach (valid_q[i]) n += valid_q[i];
            return n;
        endfunction

        // Note an accepted command and compute its result
        function void note_command(pps_pkg::cmd_t c);
            pps_pkg::rsp_t r;
            int s;
            r = '0;
            r.status = pps_pkg::ST_OK;
            case (c.operation)
                pps_pkg::OP_CREATE: begin
                    if (find_id(c.proc_id) >= 0) r.status = pps_pkg::ST_DUPLICATE;
                    else begin
                        s = -1;
                        for (int i = 0; i < NPROC; i++)
                            if (!valid_q[i]) begin s = i; break; end
                        if (s < 0) r.status = pps_pkg::ST_FULL;
                        else begin
                            valid_q[s] = 1; ident_q[s] = c.proc_id;
                            prio_q[s] = c.priority_req; left_q[s] = c.need_time;
                            used_q[s] = 0; enqueue_ready(s);
                        end
                    end
                end
                pps_pkg::OP_BLOCK: begin
                    s = find_running();
                    if (s >= 0 && ident_q[s] == c.proc_id) where_q[s] = pps_pkg::WHERE_BLOCKED;
                    else r.status = pps_pkg::ST_NOT_FOUND;
                end
                pps_pkg::OP_WAKE: begin
                    s = find_id(c.proc_id);
                    if (s >= 0 && where_q[s] == pps_pkg::WHERE_BLOCKED) enqueue_ready(s);
                    else r.status = pps_pkg::ST_NOT_FOUND;
                end
                pps_pkg::OP_KILL: begin
                    s = find_id(c.proc_id);
                    if (s >= 0) valid_q[s] = 0;
                    else r.status = pps_pkg::ST_NOT_FOUND;
                end
                pps_pkg::OP_TICK: begin
                    s = find_running();
                    if (s < 0) begin
                        s = pick_ready();
                        if (s >= 0) where_q[s] = pps_pkg::WHERE_RUNNING;
                    end
                    if (s < 0) r.status = pps_pkg::ST_IDLE;
                    else begin
                        if (used_q[s] != 16'hFFFF) used_q[s]++;
                        if (left_q[s] != 0) left_q[s]--;
                        if (left_q[s] == 0) begin
                            r.finished = 1; r.run_valid = 1;
                            r.run_id = ident_q[s]; r.run_used = used_q[s];
                            valid_q[s] = 0;
                        end
                    end
                end
                default: ;
            endcase
            if (!r.finished) begin
                s = find_running();
                if (s >= 0) begin
                    r.run_valid = 1; r.run_id = ident_q[s];
                    r.run_left = left_q[s]; r.run_used = used_q[s];
                end
            end
            pending.push_back(r);
        endfunction

        // Compare one result against the oldest expectation
        function void check_result(pps_pkg::rsp_t a);
            pps_pkg::rsp_t e;
            if (pending.size() == 0) begin
                $error("result with no expectation: %h", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, a.status); errors++; end
            if (a.run_valid !== e.run_valid) begin
                $error("run_valid exp %0d got %0d", e.run_valid, a.run_valid); errors++; end
            if (a.run_id !== e.run_id) begin
                $error("run_id exp %0d got %0d", e.run_id, a.run_id); errors++; end
            if (a.run_left !== e.run_left) begin
                $error("run_left exp %0d got %0d", e.run_left, a.run_left); errors++; end
            if (a.run_used !== e.run_used) begin
                $error("run_used exp %0d got %0d", e.run_used, a.run_used); errors++; end
            if (a.finished !== e.finished) begin
                $error("finished exp %0d got %0d", e.finished, a.finished); errors++; end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    pps_pkg::cmd_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    pps_pkg::rsp_t m_data;

    sched_scoreboard sb = new();
    int  cycle_count = 0;
    bit  calm = 0;         // no idling on either side
    bit  hold_off = 0;     // receiver long stall request
    logic [15:0] id_pool [8];

    priority_process_scheduler u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Timeout guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Monitor both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_command(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // Result channel back-pressure
    initial begin
        int n;
        @(posedge aclk);
        forever begin
            if (hold_off) begin
                m_ready <= 0;
                n = 0;
                while (n < 200) begin @(posedge aclk); n++; end
                hold_off = 0;
            end
            m_ready <= aresetn && (calm || $urandom_range(99) >= 9);
            @(posedge aclk);
        end
    end

    // Send one command; random gaps before it
    task automatic send_cmd(logic [2:0] op, logic [15:0] id, logic [7:0] pr,
                            logic [15:0] nt);
        pps_pkg::cmd_t c;
        while (!calm && $urandom_range(99) < 9) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        c.operation = op; c.proc_id = id; c.priority_req = pr; c.need_time = nt;
        s_valid <= 1;
        s_data <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic go_idle();
        s_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        go_idle();
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_id();
        return ($urandom_range(19) == 0) ? 16'($urandom) : id_pool[$urandom_range(7)];
    endfunction

    function automatic logic [15:0] pick_need();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'($urandom);
            2: return 16'hFFFF;
            default: return 16'($urandom_range(6, 1));
        endcase
    endfunction

    initial begin
        logic [2:0] op;
        int r;
        foreach (id_pool[i]) id_pool[i] = 16'($urandom);
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: idle tick, extremes, duplicates, mismatches, fill the table
        send_cmd(pps_pkg::OP_TICK, 0, 0, 0);
        send_cmd(pps_pkg::OP_CREATE, 16'h0000, 8'h00, 16'd0);
        send_cmd(pps_pkg::OP_CREATE, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_cmd(pps_pkg::OP_CREATE, 16'hFFFF, 8'h10, 16'd3);
        send_cmd(pps_pkg::OP_CREATE, 16'h1234, 8'hFF, 16'd2);
        send_cmd(pps_pkg::OP_TICK, 0, 0, 0);
        send_cmd(pps_pkg::OP_BLOCK, 16'h1234, 0, 0);
        send_cmd(pps_pkg::OP_BLOCK, 16'hFFFF, 0, 0);
        send_cmd(pps_pkg::OP_WAKE, 16'h1234, 0, 0);
        send_cmd(pps_pkg::OP_WAKE, 16'hFFFF, 0, 0);
        send_cmd(pps_pkg::OP_TICK, 0, 0, 0);
        send_cmd(pps_pkg::OP_TICK, 0, 0, 0);
        send_cmd(pps_pkg::OP_KILL, 16'hFFFF, 0, 0);
        send_cmd(pps_pkg::OP_KILL, 16'hFFFF, 0, 0);
        send_cmd(3'd5, 16'hAAAA, 8'h55, 16'h5555);
        send_cmd(3'd7, 16'h5555, 8'hAA, 16'hAAAA);
        for (int i = 0; i < 17; i++)
            send_cmd(pps_pkg::OP_CREATE, 16'(16'h100 + i), 8'(i % 3), 16'd1);
        calm = 1;
        hold_off = 1;
        for (int i = 0; i < 4; i++) send_cmd(pps_pkg::OP_TICK, 0, 0, 0);
        drain();
        calm = 0;
        for (int i = 0; i < 17; i++) send_cmd(pps_pkg::OP_KILL, 16'(16'h100 + i), 0, 0);
        send_cmd(pps_pkg::OP_TICK, 0, 0, 0);
        send_cmd(pps_pkg::OP_KILL, 16'h0000, 0, 0);

        // Random: mostly lifecycle commands over a small id pool
        for (int n = 0; n < 750; n++) begin
            if (n == 300) calm = 1;
            if (n == 380) calm = 0;
            if (n == 500) hold_off = 1;
            if (n == 600) drain();
            r = $urandom_range(99);
            if (r < 30) op = pps_pkg::OP_CREATE;
            else if (r < 42) op = pps_pkg::OP_BLOCK;
            else if (r < 54) op = pps_pkg::OP_WAKE;
            else if (r < 64) op = pps_pkg::OP_KILL;
            else if (r < 97) op = pps_pkg::OP_TICK;
            else op = 3'($urandom_range(7, 5));
            if (op == pps_pkg::OP_BLOCK && $urandom_range(3) != 0 && sb.find_running() >= 0)
                send_cmd(op, sb.ident_q[sb.find_running()], 8'($urandom), 16'($urandom));
            else if (op == pps_pkg::OP_CREATE && sb.live_count() > 10 && $urandom_range(3) != 0)
                send_cmd(pps_pkg::OP_TICK, 16'($urandom), 8'($urandom), 16'($urandom));
            else
                send_cmd(op, pick_id(), 8'($urandom), pick_need());
        end

        drain();
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
